/* hw/rtl/raster_median_filter_macros.svh */
// ---------------------------------------------------------------------------
// raster median filter assertion macros
// shared property forms for the filter's own checks
// ---------------------------------------------------------------------------
`ifndef RASTER_MEDIAN_FILTER_MACROS_SVH
`define RASTER_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication
`define RMF_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rmf check failed");

// next-cycle implication
`define RMF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rmf check failed");

`endif

/* hw/rtl/rmf_pkg.sv */
// ---------------------------------------------------------------------------
// rmf_pkg
// types and constants shared by the raster median filter
// ---------------------------------------------------------------------------
package rmf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 3;

   localparam int PIX_W     = 8;
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;
   localparam int RSP_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // what one sort cell hands to the next
   typedef struct packed {
      logic             valid;
      logic             gt;
      logic [PIX_W-1:0] val;
   } link_type;

endpackage

/* hw/rtl/raster_median_filter.sv */
// ---------------------------------------------------------------------------
// raster_median_filter
// streaming two-dimensional median filter for 8-bit pixels
// ---------------------------------------------------------------------------
// Pixels enter one per item in raster order. Each pixel is written into a
// ring of 2*MAX_RADIUS+1 line buffers. When it completes a (2*radius_x+1)
// x (2*radius_y+1) window, the window (up to 49 pixels) is read back from
// the line ram one pixel per cycle into a chain of insertion sort cells,
// and no new pixel is taken until its median has been loaded into the
// result register; a pixel that completes no window does not hold off the
// next. Border pixels produce no result. A register write restarts the frame.
module raster_median_filter #(
   parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = rmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rmf_pkg::PIX_W-1:0]     req_tdata,  // pixel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rmf_pkg::RSP_DAT_W-1:0] rsp_tdata,  // median, centre_row, centre_col
   output logic                          rsp_tlast,  // frame_last
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rmf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmf_pkg::CSR_DAT_W-1:0] csr_data
);
   import rmf_pkg::*;
   `include "raster_median_filter_macros.svh"

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int SPAN_W  = RAD_W + 1;
   localparam int RING    = 2 * MAX_RADIUS + 1;
   localparam int RING_W  = $clog2(RING);
   localparam int WIN     = RING * RING;
   localparam int WIN_W   = $clog2(WIN);
   localparam int ADDR_W  = RING_W + COL_W;
   localparam int RAM_DEP = RING * (2 ** COL_W);

   // configuration, held clamped
   logic [WDIM_W-1:0] width_ff;
   logic [HDIM_W-1:0] height_ff;
   logic [RAD_W-1:0]  rx_ff, ry_ff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [RING_W-1:0] wr_row_ff, wr_row_in;

   state_type state_ff, state_in;

   logic [SPAN_W-1:0] i_ff, j_ff;
   logic [COL_W-1:0]  base_col_ff, rd_col_ff;
   logic [RING_W-1:0] rd_row_ff;
   logic [WIN_W-1:0]  med_idx_ff;
   logic              ins_ff;

   logic [PIX_W-1:0]  med_pix;
   logic [POS_W-1:0]  crow_ff, ccol_ff;
   logic              flast_ff;

   logic                 rsp_valid_ff;
   logic [RSP_DAT_W-1:0] rsp_data_ff;
   logic                 rsp_last_ff;

   logic req_acc, win_ok, last_col, last_row, rd_last, j_last, load_out;
   logic [SPAN_W-1:0] span_x, span_y;
   logic [RING_W:0]   start_row;
   logic [PIX_W-1:0]  ram_q;
   logic [PIX_W-1:0]  vals [WIN];
   logic [2*SPAN_W-1:0] win_n;

   assign span_x  = {rx_ff, 1'b0};
   assign span_y  = {ry_ff, 1'b0};
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign win_ok   = (32'(row_ff) >= 32'(span_y)) && (32'(col_ff) >= 32'(span_x));
   assign last_col = 32'(col_ff) == 32'(width_ff) - 32'd1;
   assign last_row = 32'(row_ff) == 32'(height_ff) - 32'd1;
   assign j_last   = j_ff == span_x;
   assign rd_last  = j_last && (i_ff == span_y);
   assign win_n    = (2*SPAN_W)'(span_x + 1'b1) * (2*SPAN_W)'(span_y + 1'b1);

   always_comb begin
      start_row = (RING_W+1)'(wr_row_ff) + (RING_W+1)'(RING) - (RING_W+1)'(span_y);
      if (32'(start_row) >= RING) begin
         start_row = start_row - (RING_W+1)'(RING);
      end
   end

   always_comb begin
      col_in    = col_ff + 1'b1;
      row_in    = row_ff;
      wr_row_in = wr_row_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in    = '0;
            wr_row_in = '0;
         end else begin
            row_in    = row_ff + 1'b1;
            wr_row_in = (32'(wr_row_ff) == RING - 1) ? '0 : wr_row_ff + 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && win_ok) state_in = ST_READ;
         ST_READ:  if (rd_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DONE: load_out   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WDIM_W'(640);
         height_ff    <= HDIM_W'(480);
         rx_ff        <= RAD_W'(1);
         ry_ff        <= RAD_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         wr_row_ff    <= '0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ins_ff   <= state_ff == ST_READ;
         if (csr_valid && csr_ready) begin
            col_ff    <= '0;
            row_ff    <= '0;
            wr_row_ff <= '0;
            case (csr_index)
               CSR_IMAGE_WIDTH:
                  width_ff <= (csr_data == '0) ? WDIM_W'(1) :
                     (32'(csr_data) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(csr_data);
               CSR_IMAGE_HEIGHT:
                  height_ff <= (csr_data == '0) ? HDIM_W'(1) :
                     (32'(csr_data) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(csr_data);
               CSR_RADIUS_X:
                  rx_ff <= (32'(csr_data[1:0]) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                            : RAD_W'(csr_data[1:0]);
               CSR_RADIUS_Y:
                  ry_ff <= (32'(csr_data[1:0]) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                            : RAD_W'(csr_data[1:0]);
               default: ;
            endcase
         end else if (req_acc) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            wr_row_ff <= wr_row_in;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // window walk and result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         i_ff        <= '0;
         j_ff        <= '0;
         base_col_ff <= col_ff - COL_W'(span_x);
         rd_col_ff   <= col_ff - COL_W'(span_x);
         rd_row_ff   <= RING_W'(start_row);
         med_idx_ff  <= WIN_W'(win_n >> 1);
         crow_ff     <= POS_W'(row_ff - ROW_W'(ry_ff));
         ccol_ff     <= POS_W'(col_ff - COL_W'(rx_ff));
         flast_ff    <= last_col && last_row;
      end else if (state_ff == ST_READ) begin
         if (j_last) begin
            j_ff      <= '0;
            i_ff      <= i_ff + 1'b1;
            rd_col_ff <= base_col_ff;
            rd_row_ff <= (32'(rd_row_ff) == RING - 1) ? '0 : rd_row_ff + 1'b1;
         end else begin
            j_ff      <= j_ff + 1'b1;
            rd_col_ff <= rd_col_ff + 1'b1;
         end
      end
      if (load_out) begin
         rsp_data_ff <= RSP_DAT_W'({ccol_ff, crow_ff, med_pix});
         rsp_last_ff <= flast_ff;
      end
   end

   rmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RAM_DEP)
   ) u_lines (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (ADDR_W'({wr_row_ff, col_ff})),
      .wr_data (req_tdata),
      .rd_addr (ADDR_W'({rd_row_ff, rd_col_ff})),
      .rd_data (ram_q)
   );

   rmf_sorter #(
      .DEPTH (WIN)
   ) u_sorter (
      .clock   (clock),
      .clear   (req_acc),
      .ins     (ins_ff),
      .new_val (ram_q),
      .vals    (vals)
   );

   assign med_pix    = vals[med_idx_ff];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RMF_ASSERT_NOW(a_drain_inserts, clock, reset, state_ff == ST_DRAIN, ins_ff)
   `RMF_ASSERT_NEXT(a_window_reads, clock, reset, req_acc && win_ok, state_ff == ST_READ)
   `RMF_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && !rsp_valid_ff,
                    rsp_valid_ff)
endmodule

/* hw/rtl/rmf_ram.sv */
// ---------------------------------------------------------------------------
// rmf_ram
// single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module rmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/rmf_sort_cell.sv */
// ---------------------------------------------------------------------------
// rmf_sort_cell
// one cell of the insertion sort chain
// ---------------------------------------------------------------------------
module rmf_sort_cell (
   input  logic                      clock,
   input  logic                      clear,
   input  logic                      ins,
   input  logic [rmf_pkg::PIX_W-1:0] new_val,
   input  rmf_pkg::link_type         prev,
   output rmf_pkg::link_type         self
);
   import rmf_pkg::*;

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] val_ff, val_in;
   logic             gt;

   assign gt = valid_ff && (val_ff > new_val);

   always_comb begin
      valid_in = valid_ff;
      val_in   = val_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (ins) begin
         if (prev.gt) begin
            // larger neighbour shifts up into this cell
            valid_in = 1'b1;
            val_in   = prev.val;
         end else if (prev.valid && (!valid_ff || gt)) begin
            valid_in = 1'b1;
            val_in   = new_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      val_ff   <= val_in;
   end

   assign self = '{valid: valid_ff, gt: gt, val: val_ff};
endmodule

/* hw/rtl/rmf_sorter.sv */
// ---------------------------------------------------------------------------
// rmf_sorter
// chain of sort cells, keeps inserted values in ascending order
// ---------------------------------------------------------------------------
module rmf_sorter #(
   parameter int DEPTH = 49
) (
   input  logic                      clock,
   input  logic                      clear,
   input  logic                      ins,
   input  logic [rmf_pkg::PIX_W-1:0] new_val,
   output logic [rmf_pkg::PIX_W-1:0] vals [DEPTH]
);
   import rmf_pkg::*;

   link_type links [DEPTH+1];

   // head of the chain: always valid, never larger
   assign links[0] = '{valid: 1'b1, gt: 1'b0, val: '0};

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      rmf_sort_cell u_cell (
         .clock   (clock),
         .clear   (clear),
         .ins     (ins),
         .new_val (new_val),
         .prev    (links[k]),
         .self    (links[k+1])
      );
      assign vals[k] = links[k+1].val;
   end
endmodule

/* tb/sv/rmf_median_checker.sv */
// ---------------------------------------------------------------------------
// rmf_median_checker
// watches the filter's channels, predicts each window median and compares
// ---------------------------------------------------------------------------
// Register writes are tracked as they are accepted. Each accepted pixel is run
// through a line-store model of the filter. Every result item is compared
// with the oldest predicted window.
module rmf_median_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [rmf_pkg::PIX_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [rmf_pkg::RSP_DAT_W-1:0] rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rmf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmf_pkg::CSR_DAT_W-1:0] csr_data,
   output int                            pending,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rmf_pkg::*;

   localparam int RING = 2 * DEF_MAX_RADIUS + 1;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } window_result_type;

   logic [10:0]       cfg_width, cfg_height;
   logic [1:0]        cfg_rx, cfg_ry;
   logic [PIX_W-1:0]  line_mem [RING][DEF_MAX_WIDTH];
   int unsigned       col_pos, row_pos;
   window_result_type median_queue[$];

   task automatic filter_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w, h, rx, ry, c, r, n, k;
      logic [PIX_W-1:0] sorted [49];
      logic [PIX_W-1:0] v;
      window_result_type res;
      w = (cfg_width == 0) ? 1 : (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
      h = (cfg_height == 0) ? 1 : (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
      rx = cfg_rx;
      ry = cfg_ry;
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      line_mem[r % RING][c] = pix;
      if (r >= 2 * ry && c >= 2 * rx) begin
         n = 0;
         for (int i = 0; i <= 2 * ry; i++) begin
            for (int j = 0; j <= 2 * rx; j++) begin
               v = line_mem[(r - 2 * ry + i) % RING][c - 2 * rx + j];
               k = n;
               while (k > 0 && sorted[k-1] > v) begin
                  sorted[k] = sorted[k-1];
                  k--;
               end
               sorted[k] = v;
               n++;
            end
         end
         res.median = sorted[n / 2];
         res.row    = POS_W'(r - ry);
         res.col    = POS_W'(c - rx);
         res.last   = (r == h - 1 && c == w - 1);
         median_queue.push_back(res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   always @(posedge clock) begin
      window_result_type exp_res;
      window_result_type got_res;
      if (reset) begin
         cfg_width  = 11'd640;
         cfg_height = 11'd480;
         cfg_rx     = 2'd1;
         cfg_ry     = 2'd1;
         col_pos    = 0;
         row_pos    = 0;
         median_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width  = csr_data;
               CSR_IMAGE_HEIGHT: cfg_height = csr_data;
               CSR_RADIUS_X:     cfg_rx     = csr_data[1:0];
               CSR_RADIUS_Y:     cfg_ry     = csr_data[1:0];
               default: ;
            endcase
            col_pos = 0;
            row_pos = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_res.median = rsp_tdata[7:0];
            got_res.row    = rsp_tdata[17:8];
            got_res.col    = rsp_tdata[27:18];
            got_res.last   = rsp_tlast;
            if (median_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result item: median %0d row %0d col %0d last %0d",
                           got_res.median, got_res.row, got_res.col, got_res.last);
            end else begin
               exp_res = median_queue.pop_front();
               if (got_res !== exp_res || rsp_tdata[31:28] !== 4'd0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp median %0d row %0d col %0d last %0d, got %0d %0d %0d %0d (tdata %h)",
                              exp_res.median, exp_res.row, exp_res.col, exp_res.last,
                              got_res.median, got_res.row, got_res.col, got_res.last,
                              rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready)
            filter_pixel(req_tdata);
      end
      pending = median_queue.size();
   end

endmodule

/* tb/sv/tb_raster_median_filter.sv */
// ---------------------------------------------------------------------------
// tb_raster_median_filter
// stimulus and verdict for the raster median filter
// ---------------------------------------------------------------------------
// Runs a series of image geometries and window sizes, each set up while the
// filter is idle, and streams pixel frames through it with random gaps on
// both sides. One phase holds the result side off long enough to back up the
// input. The checker beside the filter counts any failures.
module tb_raster_median_filter;
   timeunit 1ns;
   timeprecision 1ps;
   import rmf_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   int                   pending;
   int                   fail_count;

   bit send_quiet, recv_quiet, hold_output;
   int cycle_count = 0;
   int random_items = 0;

   always #1 clock = ~clock;

   raster_median_filter u_top (.*);

   rmf_median_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall per item, plus one long hold-off
   initial begin
      int k;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         k = recv_quiet ? 0 : $urandom_range(0, 13);
         if (hold_output) begin
            k = 600;
            hold_output = 1'b0;
         end
         if (k > 0) begin
            rsp_tready <= 1'b0;
            repeat (k) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DAT_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, h, rx, ry);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      // radius writes carry random upper bits, which the filter must ignore
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_RADIUS_X, 32'({9'($urandom_range(0, 511)), 2'(rx)}));
      write_reg(CSR_RADIUS_Y, 32'({9'($urandom_range(0, 511)), 2'(ry)}));
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int k;
      k = send_quiet ? 0 : $urandom_range(0, 13);
      if (k > 0) begin
         req_tvalid <= 1'b0;
         repeat (k) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [PIX_W-1:0] draw_pixel();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       return PIX_W'($urandom_range(60, 68));
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int unsigned w, h, n;
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      hold_output = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 5x5, 3x3 window: extremes and alternating bit patterns
      set_geometry(5, 5, 1, 1);
      for (int i = 0; i < 25; i++) begin
         case (i % 4)
            0: send_pixel(8'h00);
            1: send_pixel(8'hFF);
            2: send_pixel(8'h55);
            default: send_pixel(8'hAA);
         endcase
      end
      // single pixel image, 1x1 window: every item is the last of its frame
      set_geometry(1, 1, 0, 0);
      for (int i = 0; i < 6; i++) send_pixel(draw_pixel());
      // largest window
      set_geometry(7, 8, 3, 3);
      for (int i = 0; i < 60; i++) send_pixel(draw_pixel());
      // window larger than the image: no results
      set_geometry(3, 3, 3, 2);
      for (int i = 0; i < 12; i++) send_pixel(draw_pixel());
      // zero width taken as one, oversize height saturated
      send_quiet = 1'b1;
      recv_quiet = 1'b1;
      set_geometry(0, 2047, 0, 1);
      for (int i = 0; i < 40; i++) send_pixel(draw_pixel());
      // oversize width saturated; long output hold-off backs up the input
      send_quiet = 1'b0;
      set_geometry(2047, 1, 1, 0);
      hold_output = 1'b1;
      for (int i = 0; i < 100; i++) send_pixel(draw_pixel());
      set_geometry(1024, 2, 0, 1);
      for (int i = 0; i < 40; i++) send_pixel(draw_pixel());

      while (random_items < 110) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 8);
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         set_geometry(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
         n = w * h + $urandom_range(0, w * h);
         for (int i = 0; i < n; i++) send_pixel(draw_pixel());
         random_items += n;
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_ram.sv
hw/rtl/rmf_sort_cell.sv
hw/rtl/rmf_sorter.sv
hw/rtl/raster_median_filter.sv
tb/sv/rmf_median_checker.sv
tb/sv/tb_raster_median_filter.sv
